// File: hw/rtl/motion_vector_predictor_core_assert.svh
// Assertion macros for the motion vector predictor core.
// No dependencies; taken in by the files that carry assertions.
`ifndef MOTION_VECTOR_PREDICTOR_CORE_ASSERT_SVH
`define MOTION_VECTOR_PREDICTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MVP_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define MVP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mvp_pkg.sv
// Shared constants of the motion vector predictor core.
// No dependencies; imported by the core and the testbench.
package mvp_pkg;

	// Width of the vector fields on the ports
	localparam int FIELD_W = 16;
	// Width of the row width register
	localparam int CFG_W = 9;
	// Row width after reset
	localparam int ROW_WIDTH_RST = 1;

endpackage

// File: hw/rtl/mvp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced by the motion vector predictor core.
module mvp_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old contents when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/motion_vector_predictor_core.sv
// Motion vector predictor core: neighbour-based vector prediction over a one-row store.
// Depends on mvp_pkg, mvp_ram and motion_vector_predictor_core_assert.svh.
//
// Usage
//   Input channel (in_valid/in_ready): one block per transfer in raster order, with
//   frame_start, is_inter, vec_x and vec_y. frame_start marks column 0, row 0.
//   Output channel (out_valid/out_ready): one prediction (pred_x, pred_y) per block,
//   in the order the blocks arrived.
//   Configuration: cfg_we writes cfg_data into the row width (blocks per row) at the
//   clock edge; zero acts as one, values above MAX_ROW_BLOCKS saturate. Write it
//   only while no block is in flight.
//   Path: an accepted block passes the read stage, then the output register.
//   Throughput: one block per cycle while results are taken, set by the single
//   read and single write port of the row store (read at acceptance, write-back on read-stage exit).
//   Stall: while the output register holds an untaken result, the block in the
//   read stage waits and in_ready drops; nothing is lost or repeated.
//   Reset: arst_n clears the pipeline, the position (column 0, first row) and the
//   neighbour registers, and sets the row width to one. The row store needs no
//   clearing pass: every entry is written in the first row before it is read.
`include "motion_vector_predictor_core_assert.svh"

module motion_vector_predictor_core #(
	parameter int MAX_ROW_BLOCKS = 256,
	parameter int VEC_WIDTH      = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [mvp_pkg::CFG_W-1:0]            cfg_data,
	// block input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 frame_start,
	input  logic                                 is_inter,
	input  logic signed [mvp_pkg::FIELD_W-1:0]   vec_x,
	input  logic signed [mvp_pkg::FIELD_W-1:0]   vec_y,
	// prediction output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mvp_pkg::FIELD_W-1:0]   pred_x,
	output logic signed [mvp_pkg::FIELD_W-1:0]   pred_y
);

	import mvp_pkg::*;

	localparam int CW   = $clog2(MAX_ROW_BLOCKS);
	localparam int RWW  = $clog2(MAX_ROW_BLOCKS + 1);
	localparam int CMPW = (RWW > CFG_W) ? RWW : CFG_W;
	localparam int MAXW = (VEC_WIDTH > FIELD_W) ? VEC_WIDTH : FIELD_W;

	// One store entry: inter flag and the vector
	typedef struct packed {
		logic                        inter;
		logic signed [VEC_WIDTH-1:0] x;
		logic signed [VEC_WIDTH-1:0] y;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// Per component: left if |top - topleft| < |left - topleft|, else top
	function automatic logic signed [VEC_WIDTH-1:0] pick(
		input logic signed [VEC_WIDTH-1:0] l,
		input logic signed [VEC_WIDTH-1:0] t,
		input logic signed [VEC_WIDTH-1:0] tl
	);
		logic signed [VEC_WIDTH:0] d_t;
		logic signed [VEC_WIDTH:0] d_l;
		logic [VEC_WIDTH:0]        a_t;
		logic [VEC_WIDTH:0]        a_l;
		d_t = (VEC_WIDTH+1)'(t) - (VEC_WIDTH+1)'(tl);
		d_l = (VEC_WIDTH+1)'(l) - (VEC_WIDTH+1)'(tl);
		a_t = d_t[VEC_WIDTH] ? $unsigned(-d_t) : $unsigned(d_t);
		a_l = d_l[VEC_WIDTH] ? $unsigned(-d_l) : $unsigned(d_l);
		return (a_t < a_l) ? l : t;
	endfunction

	// Configuration and position state
	logic [CMPW-1:0] rw_eff_q;
	logic [CW-1:0]   column_q;
	logic            first_row_q;

	// Read stage
	logic            valid_s1;
	logic [CW-1:0]   col_s1;
	logic            first_row_s1;
	entry_t          cur_s1;
	logic            fwd_s1;
	entry_t          fwd_data_s1;

	// Neighbour registers
	entry_t          left_q;
	entry_t          topleft_q;

	// Output register
	logic                         out_valid_q;
	logic signed [FIELD_W-1:0]    pred_x_q;
	logic signed [FIELD_W-1:0]    pred_y_q;

	logic            s1_adv;
	logic            in_fire;
	logic [CW-1:0]   cur_col;
	logic            cur_fr;
	logic            wrap;
	entry_t          cur_in;
	logic [EW-1:0]   ram_rdata;
	entry_t          top_raw;
	entry_t          nb_l;
	entry_t          nb_t;
	entry_t          nb_tl;
	logic signed [VEC_WIDTH-1:0] px;
	logic signed [VEC_WIDTH-1:0] py;

	// Advance the read stage when the output register is free or being emptied
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// Frame start restarts the position before the lookup
	assign cur_col = frame_start ? '0 : column_q;
	assign cur_fr  = frame_start || first_row_q;
	assign wrap    = (CMPW'(cur_col) + CMPW'(1)) >= rw_eff_q;

	// Fields wider than VEC_WIDTH are cut; narrower ones are taken as unsigned
	always_comb begin
		cur_in.inter = is_inter;
		cur_in.x     = VEC_WIDTH'(MAXW'($unsigned(vec_x)));
		cur_in.y     = VEC_WIDTH'(MAXW'($unsigned(vec_y)));
	end

	mvp_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ROW_BLOCKS)
	) u_row_store (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (cur_s1),
		.re    (in_fire),
		.raddr (cur_col),
		.rdata (ram_rdata)
	);

	// The store returns stale data when the entry was written in the read cycle
	assign top_raw = fwd_s1 ? fwd_data_s1 : entry_t'(ram_rdata);

	// Neighbours outside the frame or not inter-coded count as zero
	always_comb begin
		nb_l  = (col_s1 != '0 && left_q.inter) ? left_q : '0;
		nb_t  = (!first_row_s1 && top_raw.inter) ? top_raw : '0;
		nb_tl = (!first_row_s1 && col_s1 != '0 && topleft_q.inter) ? topleft_q : '0;
		px    = pick(nb_l.x, nb_t.x, nb_tl.x);
		py    = pick(nb_l.y, nb_t.y, nb_tl.y);
	end

	// Row width register: zero taken as one, larger values saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw_eff_q <= CMPW'(ROW_WIDTH_RST);
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				rw_eff_q <= CMPW'(1);
			end else if (CMPW'(cfg_data) > CMPW'(MAX_ROW_BLOCKS)) begin
				rw_eff_q <= CMPW'(MAX_ROW_BLOCKS);
			end else begin
				rw_eff_q <= CMPW'(cfg_data);
			end
		end
	end

	// Position and read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
			valid_s1    <= 1'b0;
		end else begin
			if (in_fire) begin
				column_q    <= wrap ? '0 : CW'(cur_col + CW'(1));
				first_row_q <= wrap ? 1'b0 : cur_fr;
				valid_s1    <= 1'b1;
			end else if (s1_adv) begin
				valid_s1    <= 1'b0;
			end
		end
	end

	// Read stage payload; flag a lookup of the entry being written back
	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1       <= cur_col;
			first_row_s1 <= cur_fr;
			cur_s1       <= cur_in;
			fwd_s1       <= s1_adv && (col_s1 == cur_col);
			fwd_data_s1  <= cur_s1;
		end
	end

	// Neighbour registers move on with each finished block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			topleft_q <= '0;
		end else if (s1_adv) begin
			left_q    <= cur_s1;
			topleft_q <= top_raw;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pred_x_q <= FIELD_W'(px);
			pred_y_q <= FIELD_W'(py);
		end
	end

	assign out_valid = out_valid_q;
	assign pred_x    = pred_x_q;
	assign pred_y    = pred_y_q;

	// A held block keeps its position and forwarding decision
	`MVP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv, valid_s1 && $stable(col_s1) && $stable(fwd_s1), "read stage lost a held block")
	// A frame start lands at column 0 of the first row
	`MVP_ASSERT_NEXT(a_frame_restart, clk, arst_n, in_fire && frame_start, first_row_s1 && col_s1 == '0, "frame start did not restart the position")
	// A result appears only after a block left the read stage
	`MVP_ASSERT_IMPLY(a_out_source, clk, arst_n, $rose(out_valid_q), $past(valid_s1), "result without a block in the read stage")

endmodule

// File: sim/motion_vector_predictor_core_tb.sv
// Self-checking testbench for motion_vector_predictor_core: a directed table, then random frames.
// Depends on mvp_pkg and the core; predictions are worked out by a behavioural model held here.
module motion_vector_predictor_core_tb;
	import mvp_pkg::*;

	localparam int MAX_BLOCKS   = 256;
	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 8;
	localparam int REPORT_MAX   = 10;

	// One block as the model keeps it: inter flag plus vector
	typedef struct packed {
		logic                      inter;
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
	} mv_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
	} pred_pair_t;

	typedef enum logic {STEP_BLOCK, STEP_CFG} step_kind_e;

	// Directed step: a block (with a typed prediction where it is obvious) or a row width write
	typedef struct {
		step_kind_e kind;
		bit         fs;
		bit         inter;
		int         vx;
		int         vy;
		bit         typed;
		int         ex;
		int         ey;
		int         width;
	} dir_row_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_we      = 1'b0;
	logic [CFG_W-1:0]          cfg_data    = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      frame_start = 1'b0;
	logic                      is_inter    = 1'b0;
	logic signed [FIELD_W-1:0] vec_x       = '0;
	logic signed [FIELD_W-1:0] vec_y       = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic signed [FIELD_W-1:0] pred_x;
	logic signed [FIELD_W-1:0] pred_y;

	motion_vector_predictor_core #(
		.MAX_ROW_BLOCKS (MAX_BLOCKS),
		.VEC_WIDTH      (FIELD_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_start (frame_start),
		.is_inter    (is_inter),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pred_x      (pred_x),
		.pred_y      (pred_y)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Neighbour model: its own copy of the row store, the left and
	// top-left registers, the position and the row width.
	// ------------------------------------------------------------------
	mv_t              row_mem [MAX_BLOCKS];
	mv_t              left_nb;
	mv_t              topleft_nb;
	int unsigned      col_pos;
	bit               in_first_row;
	logic [CFG_W-1:0] width_reg;

	pred_pair_t predicted_vectors[$];

	int fail_count    = 0;
	int results_seen  = 0;
	int directed_sent = 0;
	int random_sent   = 0;
	int width_writes  = 0;
	int left_picks    = 0;
	int top_picks     = 0;
	int cycles        = 0;
	int sink_hold     = 0;
	bit send_quiet    = 1'b0;
	bit sink_quiet    = 1'b0;

	// Left wins only when top is strictly closer to top-left than left is; ties go to top
	function automatic logic signed [FIELD_W-1:0] pick_component(
		input logic signed [FIELD_W-1:0] l,
		input logic signed [FIELD_W-1:0] t,
		input logic signed [FIELD_W-1:0] tl
	);
		int dt;
		int dl;
		dt = int'(t) - int'(tl);
		dl = int'(l) - int'(tl);
		if (dt < 0) dt = -dt;
		if (dl < 0) dl = -dl;
		if (dt < dl) begin
			left_picks++;
			return l;
		end
		top_picks++;
		return t;
	endfunction

	// Predict one block, then store it and advance the position
	function automatic void predict_block(input bit fs, input mv_t cur, output pred_pair_t pp);
		int unsigned eff;
		int unsigned c;
		mv_t         top_raw;
		mv_t         l;
		mv_t         t;
		mv_t         tl;
		eff = (width_reg == 0) ? 1 : ((width_reg > MAX_BLOCKS) ? MAX_BLOCKS : width_reg);
		if (fs) begin
			col_pos      = 0;
			in_first_row = 1'b1;
		end
		c       = col_pos % MAX_BLOCKS;
		top_raw = row_mem[c];
		l       = '0;
		t       = '0;
		tl      = '0;
		// outside the frame or intra: the neighbour counts as zero
		if (c > 0 && left_nb.inter)
			l = left_nb;
		if (!in_first_row && top_raw.inter)
			t = top_raw;
		if (!in_first_row && c > 0 && topleft_nb.inter)
			tl = topleft_nb;
		pp.x = pick_component(l.x, t.x, tl.x);
		pp.y = pick_component(l.y, t.y, tl.y);
		topleft_nb = top_raw;
		left_nb    = cur;
		row_mem[c] = cur;
		// a shrunk width can leave the column past the end: wrap all the same
		if (c + 1 >= eff) begin
			col_pos      = 0;
			in_first_row = 1'b0;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// Idle count for one transfer; now and then flip into or out of a run with no idling
	function automatic int draw_gap(inout bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	// Mostly small values so that ties and near-ties are common; some extremes and full range
	function automatic logic signed [FIELD_W-1:0] rand_component();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return FIELD_W'($signed($urandom_range(0, 8)) - 4);
			5, 6:          return FIELD_W'($signed($urandom_range(0, 600)) - 300);
			7: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default:       return FIELD_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Block source. The caller is always at a rising edge; valid is
	// only lowered when a gap follows, so it never drops and rises in
	// the same step.
	// ------------------------------------------------------------------
	task automatic send_block(
		input bit                        fs,
		input bit                        inter,
		input logic signed [FIELD_W-1:0] x,
		input logic signed [FIELD_W-1:0] y,
		input bit                        typed,
		input logic signed [FIELD_W-1:0] ex,
		input logic signed [FIELD_W-1:0] ey
	);
		int         gap;
		pred_pair_t pp;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_block(fs, '{inter, x, y}, pp);
		// a typed row overrides the model, which still advances its state
		if (typed) begin
			pp.x = ex;
			pp.y = ey;
		end
		in_valid    <= 1'b1;
		frame_start <= fs;
		is_inter    <= inter;
		vec_x       <= x;
		vec_y       <= y;
		// hold the payload until the transfer
		do @(posedge clk); while (!in_ready);
		predicted_vectors.push_back(pp);
	endtask

	// Write the row width only once the core has drained
	task automatic write_row_width(input logic [CFG_W-1:0] w);
		in_valid <= 1'b0;
		while (predicted_vectors.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		width_reg  = w;
		width_writes++;
	endtask

	// One frame at the current width, with the odd frame restart thrown in as noise
	task automatic run_frame(input int n);
		bit fs;
		for (int i = 0; i < n; i++) begin
			fs = (i == 0) || ($urandom_range(0, 49) == 0);
			send_block(fs, $urandom_range(0, 3) != 0, rand_component(), rand_component(),
				1'b0, '0, '0);
			random_sent++;
		end
	endtask

	// Directed steps. Typed predictions only where they follow at once: first row, and
	// row width one, where the top neighbour alone decides.
	dir_row_t dir_rows [27] = '{
		// reset width of one: every block is its own row
		'{STEP_BLOCK, 1'b0, 1'b1,  32767, -32768, 1'b1,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1, -32768,  32767, 1'b1,  32767, -32768, 0},
		'{STEP_BLOCK, 1'b0, 1'b0,   4660,  -4660, 1'b1, -32768,  32767, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,     -1,     -1, 1'b1,      0,      0, 0},
		'{STEP_BLOCK, 1'b1, 1'b1,      5,     -5, 1'b1,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b0,      0,      0, 1'b1,      5,     -5, 0},
		// zero width behaves as one
		'{STEP_CFG,   1'b0, 1'b0,      0,      0, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b1, 1'b1, -21846,  21845, 1'b1,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,  21845, -21846, 1'b1, -21846,  21845, 0},
		// three wide: full first row, then a row whose middle block uses all three neighbours
		'{STEP_CFG,   1'b0, 1'b0,      0,      0, 1'b0,      0,      0, 3},
		'{STEP_BLOCK, 1'b1, 1'b1,     10,     20, 1'b1,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,     13,     -7, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b0,    100,    100, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,    -50,      3, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,     12,     -8, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,      7,      7, 1'b0,      0,      0, 0},
		// four wide, then shrunk to two in the middle of the second row
		'{STEP_CFG,   1'b0, 1'b0,      0,      0, 1'b0,      0,      0, 4},
		'{STEP_BLOCK, 1'b1, 1'b1,      1,      1, 1'b1,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,      2,      2, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,      3,      3, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,      4,      4, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,      0,     -3, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b0,     -2,      2, 1'b0,      0,      0, 0},
		'{STEP_CFG,   1'b0, 1'b0,      0,      0, 1'b0,      0,      0, 2},
		'{STEP_BLOCK, 1'b0, 1'b1,      9,      9, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,      1,     -1, 1'b0,      0,      0, 0},
		'{STEP_BLOCK, 1'b0, 1'b1,     -4,      4, 1'b0,      0,      0, 0}
	};

	// ------------------------------------------------------------------
	// Prediction sink: check each transfer against the oldest
	// expectation, then draw the stall before the next one.
	// ------------------------------------------------------------------
	pred_pair_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_hold  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_vectors.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected prediction (%0d,%0d) with none awaited",
							pred_x, pred_y);
				end else begin
					want = predicted_vectors.pop_front();
					if (pred_x !== want.x || pred_y !== want.y) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("block %0d: expected (%0d,%0d), got (%0d,%0d)",
								results_seen, want.x, want.y, pred_x, pred_y);
					end
				end
				results_seen++;
				sink_hold = draw_gap(sink_quiet);
			end
			// drop ready for the drawn stall, otherwise hold it high
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions still awaited",
				cycles, predicted_vectors.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// model state after reset; the row store is never read before it is written
		foreach (row_mem[i])
			row_mem[i] = '0;
		left_nb      = '0;
		topleft_nb   = '0;
		col_pos      = 0;
		in_first_row = 1'b1;
		width_reg    = CFG_W'(ROW_WIDTH_RST);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == STEP_CFG) begin
				write_row_width(CFG_W'(dir_rows[i].width));
			end else begin
				send_block(dir_rows[i].fs, dir_rows[i].inter,
					FIELD_W'(dir_rows[i].vx), FIELD_W'(dir_rows[i].vy),
					dir_rows[i].typed, FIELD_W'(dir_rows[i].ex), FIELD_W'(dir_rows[i].ey));
				directed_sent++;
			end
		end

		// all-ones width saturates to the full store: one long run of more blocks than a row holds
		write_row_width('1);
		run_frame(300);
		// then short frames at small widths; every width change starts a new frame,
		// so a widened row never reaches an entry that was not written
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0:       write_row_width('0);
				1:       write_row_width(CFG_W'(1));
				2:       write_row_width(CFG_W'(2));
				default: write_row_width(CFG_W'($urandom_range(3, 12)));
			endcase
			run_frame($urandom_range(15, 50));
		end

		in_valid <= 1'b0;
		while (predicted_vectors.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (predicted_vectors.size() != 0)
			fail_count++;
		$display("%0d blocks (%0d directed, %0d random) over %0d row width writes, %0d predictions",
			directed_sent + random_sent, directed_sent, random_sent, width_writes, results_seen);
		$display("component choices: left %0d, top %0d; failures %0d",
			left_picks, top_picks, fail_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mvp_pkg.sv
hw/rtl/mvp_ram.sv
hw/rtl/motion_vector_predictor_core.sv
sim/motion_vector_predictor_core_tb.sv
